### design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RRP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RRP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rrp_pkg.sv
`default_nettype none
package rrp_pkg;

   // Ring size in bytes; must be a power of two.
   localparam int RING_BYTES = 32768;
   localparam int RING_BITS  = $clog2(RING_BYTES);

   localparam int BYTE_W   = 8;
   localparam int HALF_W   = 16;
   localparam int OFFSET_W = 15;
   localparam int POS_W    = 17;
   localparam int SUM_W    = 17;

   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSOLE_ETYPE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IP_ETYPE      = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IP_LEN    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IP_LEN    = 8'd3;

   localparam logic [HALF_W-1:0] CONSOLE_ETYPE_RST = 16'h88B5;
   localparam logic [HALF_W-1:0] IP_ETYPE_RST      = 16'h0800;
   localparam logic [HALF_W-1:0] MIN_IP_LEN_RST    = 16'd42;
   localparam logic [HALF_W-1:0] MAX_IP_LEN_RST    = 16'd1599;

   // Header byte positions.
   localparam logic [POS_W-1:0] POS_STATUS_LO = 17'd0;
   localparam logic [POS_W-1:0] POS_STATUS_HI = 17'd1;
   localparam logic [POS_W-1:0] POS_LEN_LO    = 17'd2;
   localparam logic [POS_W-1:0] POS_LEN_HI    = 17'd3;
   localparam logic [POS_W-1:0] HDR_BYTES     = 17'd4;

   // Frame byte positions.
   localparam logic [POS_W-1:0] FRM_TYPE_HI   = 17'd12;
   localparam logic [POS_W-1:0] FRM_TYPE_LO   = 17'd13;
   localparam logic [POS_W-1:0] FRM_CONSOLE   = 17'd14;
   localparam logic [POS_W-1:0] FRM_IP_START  = 17'd42;
   localparam logic [POS_W:0]   FRM_IP_TAIL   = 18'd5;

   localparam logic [SUM_W-1:0]  ALIGN_ROUND   = 17'd7;
   localparam logic [HALF_W-1:0] READ_PTR_BIAS = 16'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [BYTE_W-1:0] char_byte;
      logic              emit;
      logic              end_rec;
      logic              ok;
      logic [HALF_W-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

### design/rrp_if.sv
`default_nettype none
interface rrp_req_if;
   logic                       valid;
   logic                       ready;
   logic [rrp_pkg::BYTE_W-1:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rrp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrp_pkg::BYTE_W-1:0]   out_char;
   logic                         char_valid;
   logic                         record_end;
   logic                         record_ok;
   logic [rrp_pkg::OFFSET_W-1:0] next_offset;
   logic [rrp_pkg::HALF_W-1:0]   read_pointer_value;
   modport source (output valid, output out_char, output char_valid, output record_end,
                   output record_ok, output next_offset, output read_pointer_value,
                   input ready);
   modport sink   (input valid, input out_char, input char_valid, input record_end,
                   input record_ok, input next_offset, input read_pointer_value,
                   output ready);
endinterface

interface rrp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [rrp_pkg::CSR_IDX_W-1:0] index;
   logic [rrp_pkg::HALF_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/rrp_front.sv
`default_nettype none
module rrp_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [rrp_pkg::BYTE_W-1:0]   rx_byte,
   input  wire                          csr_valid,
   input  wire  [rrp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire  [rrp_pkg::HALF_W-1:0]   csr_data,
   input  wire  rrp_pkg::queue_status_type q_status,
   output logic                         push,
   output rrp_pkg::cmd_type             push_cmd
);

   logic [rrp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [rrp_pkg::HALF_W-1:0] len_ff, len_in;
   logic [rrp_pkg::HALF_W-1:0] ftype_ff, ftype_in;
   logic [rrp_pkg::HALF_W-1:0] console_et_ff, ip_et_ff, min_len_ff, max_len_ff;
   logic [rrp_pkg::POS_W-1:0]  frm;
   logic                       accept;
   logic                       ip_ok;
   rrp_pkg::cmd_type           cmd;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign frm      = pos_ff - rrp_pkg::HDR_BYTES;

   assign ip_ok = (ftype_ff == ip_et_ff) && (len_ff >= min_len_ff) && (len_ff <= max_len_ff)
                  && (frm >= rrp_pkg::FRM_IP_START)
                  && (({1'b0, frm} + rrp_pkg::FRM_IP_TAIL) <= {2'b00, len_ff});

   always_comb begin
      pos_in        = pos_ff;
      len_in        = len_ff;
      ftype_in      = ftype_ff;
      cmd.char_byte = rx_byte;
      cmd.emit      = 1'b0;
      cmd.end_rec   = 1'b0;
      cmd.ok        = 1'b0;
      if (pos_ff == rrp_pkg::POS_STATUS_LO) begin
         len_in   = '0;
         ftype_in = '0;
         if (!rx_byte[0]) begin
            cmd.end_rec = 1'b1;
         end else begin
            pos_in = rrp_pkg::POS_STATUS_HI;
         end
      end else if (pos_ff == rrp_pkg::POS_STATUS_HI) begin
         pos_in = rrp_pkg::POS_LEN_LO;
      end else if (pos_ff == rrp_pkg::POS_LEN_LO) begin
         len_in = {8'h00, rx_byte};
         pos_in = rrp_pkg::POS_LEN_HI;
      end else if (pos_ff == rrp_pkg::POS_LEN_HI) begin
         len_in = {rx_byte, len_ff[7:0]};
         if (len_in == '0) begin
            cmd.end_rec = 1'b1;
            cmd.ok      = 1'b1;
            pos_in      = '0;
         end else begin
            pos_in = rrp_pkg::HDR_BYTES;
         end
      end else begin
         if (frm == rrp_pkg::FRM_TYPE_HI) begin
            ftype_in = {rx_byte, 8'h00};
         end else if (frm == rrp_pkg::FRM_TYPE_LO) begin
            ftype_in = {ftype_ff[15:8], rx_byte};
         end
         if (frm >= rrp_pkg::FRM_CONSOLE) begin
            // console type wins when both registers match
            if (ftype_ff == console_et_ff) begin
               cmd.emit = (frm == rrp_pkg::FRM_CONSOLE);
            end else begin
               cmd.emit = ip_ok;
            end
         end
         if (({1'b0, frm} + 18'd1) >= {2'b00, len_ff}) begin
            cmd.end_rec = 1'b1;
            cmd.ok      = 1'b1;
            pos_in      = '0;
         end else begin
            pos_in = pos_ff + 17'd1;
         end
      end
      cmd.length = len_in;
   end

   assign push     = accept && (cmd.emit || cmd.end_rec);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         ftype_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         ftype_ff <= ftype_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         console_et_ff <= rrp_pkg::CONSOLE_ETYPE_RST;
         ip_et_ff      <= rrp_pkg::IP_ETYPE_RST;
         min_len_ff    <= rrp_pkg::MIN_IP_LEN_RST;
         max_len_ff    <= rrp_pkg::MAX_IP_LEN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            rrp_pkg::CSR_CONSOLE_ETYPE: console_et_ff <= csr_data;
            rrp_pkg::CSR_IP_ETYPE:      ip_et_ff      <= csr_data;
            rrp_pkg::CSR_MIN_IP_LEN:    min_len_ff    <= csr_data;
            rrp_pkg::CSR_MAX_IP_LEN:    max_len_ff    <= csr_data;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

### design/rrp_queue.sv
`default_nettype none
`include "assert_macros.svh"
module rrp_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push,
   input  wire  rrp_pkg::cmd_type     push_cmd,
   input  wire                        pop,
   output rrp_pkg::cmd_type           pop_cmd,
   output rrp_pkg::queue_status_type  status
);

   rrp_pkg::cmd_type              entry_ff [rrp_pkg::QUEUE_DEPTH];
   logic [rrp_pkg::QUEUE_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [rrp_pkg::QUEUE_AW:0]    count_ff;

   assign status.full  = (count_ff == (rrp_pkg::QUEUE_AW + 1)'(rrp_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `RRP_ASSERT(a_no_overflow, clock, reset, status.full |-> !push, "push into full queue")
   `RRP_ASSERT(a_no_underflow, clock, reset, status.empty |-> !pop, "pop from empty queue")
   `RRP_ASSERT(a_count_step, clock, reset,
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "count did not advance")

endmodule
`default_nettype wire

### design/rrp_back.sv
`default_nettype none
`include "assert_macros.svh"
module rrp_back (
   input  wire                           clock,
   input  wire                           reset,
   input  wire  rrp_pkg::queue_status_type q_status,
   input  wire  rrp_pkg::cmd_type        pop_cmd,
   output logic                          pop,
   output logic                          out_valid,
   input  wire                           out_ready,
   output logic [rrp_pkg::BYTE_W-1:0]    out_char,
   output logic                          char_valid,
   output logic                          record_end,
   output logic                          record_ok,
   output logic [rrp_pkg::OFFSET_W-1:0]  next_offset,
   output logic [rrp_pkg::HALF_W-1:0]    read_pointer_value
);

   logic [rrp_pkg::OFFSET_W-1:0] ring_ff, ring_in;
   logic                         valid_ff;
   logic [rrp_pkg::BYTE_W-1:0]   char_ff;
   logic                         cvalid_ff, end_ff, ok_ff;
   logic [rrp_pkg::OFFSET_W-1:0] noff_ff, noff_in;
   logic [rrp_pkg::HALF_W-1:0]   rptr_ff, rptr_in;
   logic [rrp_pkg::SUM_W-1:0]    sum, aligned;
   logic [rrp_pkg::OFFSET_W-1:0] wrapped;
   logic                         close_ok;

   assign pop = !q_status.empty && (!valid_ff || out_ready);

   assign sum      = {2'b00, ring_ff} + {1'b0, pop_cmd.length} + rrp_pkg::ALIGN_ROUND;
   assign aligned  = {sum[rrp_pkg::SUM_W-1:2], 2'b00};
   // power-of-two ring: modulo is a mask
   assign wrapped  = rrp_pkg::OFFSET_W'(aligned & rrp_pkg::SUM_W'(rrp_pkg::RING_BYTES - 1));
   assign close_ok = pop_cmd.end_rec && pop_cmd.ok;

   always_comb begin
      ring_in = ring_ff;
      noff_in = '0;
      rptr_in = '0;
      if (close_ok) begin
         ring_in = wrapped;
         noff_in = wrapped;
         rptr_in = {1'b0, wrapped} - rrp_pkg::READ_PTR_BIAS;
      end else if (pop_cmd.end_rec) begin
         noff_in = ring_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ring_ff  <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            ring_ff  <= ring_in;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         char_ff   <= pop_cmd.emit ? pop_cmd.char_byte : '0;
         cvalid_ff <= pop_cmd.emit;
         end_ff    <= pop_cmd.end_rec;
         ok_ff     <= close_ok;
         noff_ff   <= noff_in;
         rptr_ff   <= rptr_in;
      end
   end

   assign out_valid          = valid_ff;
   assign out_char           = char_ff;
   assign char_valid         = cvalid_ff;
   assign record_end         = end_ff;
   assign record_ok          = ok_ff;
   assign next_offset        = noff_ff;
   assign read_pointer_value = rptr_ff;

   `RRP_ASSERT(a_ok_needs_end, clock, reset, (valid_ff && ok_ff) |-> end_ff,
      "record_ok without record_end")
   `RRP_ASSERT(a_item_nonempty, clock, reset, valid_ff |-> (cvalid_ff || end_ff),
      "empty result item")
   `RRP_ASSERT(a_offset_aligned, clock, reset, (valid_ff && end_ff) |-> (noff_ff[1:0] == 2'b00),
      "next offset not word aligned")
   `RRP_ASSERT(a_ring_holds, clock, reset,
      (!$past(reset) && !$past(pop && close_ok)) |-> $stable(ring_ff),
      "ring offset moved without a closed record")

endmodule
`default_nettype wire

### design/rx_ring_record_parser_core.sv
// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    rx_byte[7:0]
// rsp_ch    out  valid/ready    out_char, char_valid, record_end, record_ok,
//                               next_offset[14:0], read_pointer_value[15:0]
// csr_ch    in   valid/ready    index[7:0], data[15:0]
//
// One byte can transfer every cycle while the queue is not full. A byte that yields a result is
// classified and queued at its transfer edge, then loaded from the queue into the output register
// when it reaches the queue head and the output register is empty or being taken.
// Stalls on rsp_ch fill a four-entry queue; req_ch.ready drops only when it is full.
// csr_ch.ready is always high; register writes take effect the next cycle.
// Reset is synchronous and restores the default registers and ring offset zero.
`default_nettype none
module rx_ring_record_parser_core (
   input  wire       clock,
   input  wire       reset,
   rrp_req_if.sink   req_ch,
   rrp_rsp_if.source rsp_ch,
   rrp_csr_if.sink   csr_ch
);

   rrp_pkg::cmd_type          push_cmd, pop_cmd;
   rrp_pkg::queue_status_type q_status;
   logic                      push, pop;

   assign csr_ch.ready = 1'b1;

   rrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .rx_byte   (req_ch.rx_byte),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   rrp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   rrp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_status           (q_status),
      .pop_cmd            (pop_cmd),
      .pop                (pop),
      .out_valid          (rsp_ch.valid),
      .out_ready          (rsp_ch.ready),
      .out_char           (rsp_ch.out_char),
      .char_valid         (rsp_ch.char_valid),
      .record_end         (rsp_ch.record_end),
      .record_ok          (rsp_ch.record_ok),
      .next_offset        (rsp_ch.next_offset),
      .read_pointer_value (rsp_ch.read_pointer_value)
   );

endmodule
`default_nettype wire
